// ===== sv/gvr_pkg.sv =====
// ----------------------------------------------------------------------------
// gvr_pkg: shared types, constants and step functions
// Types and arithmetic steps for the Givens rotation construction pipeline.
// ----------------------------------------------------------------------------
package gvr_pkg;

	// queue between front and back; depth must be a power of two
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);

	localparam int SqrtSteps  = 32;
	localparam int DivSteps   = 31;
	localparam int RecipSteps = 32;

	localparam logic [30:0] OneQ30     = 31'h4000_0000;
	localparam logic [30:0] RecipSmall = 31'h0000_4000;
	localparam logic [31:0] ZOneQ16    = 32'h0001_0000;
	localparam logic [31:0] ZPosMax    = 32'h7fff_ffff;
	localparam logic [31:0] ZNegMin    = 32'h8000_0000;

	typedef struct packed {
		logic        aneg;
		logic        bneg;
		logic        rneg;
		logic        abig;
		logic        zero;
		logic [31:0] amag;
		logic [31:0] bmag;
	} gvr_cls_t;

	typedef struct packed {
		gvr_cls_t    cls;
		logic [63:0] sum;
	} gvr_work_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} gvr_sq_t;

	typedef struct packed {
		logic [32:0] rem;
		logic        qbit;
	} gvr_div_t;

	// one bit of a restoring square root
	function automatic gvr_sq_t sqrt_step(gvr_sq_t cur, logic [1:0] pair);
		logic [35:0] sh;
		logic [35:0] trial;
		gvr_sq_t     nxt;
		sh    = {cur.rem, pair};
		trial = {2'b00, cur.root, 2'b01};
		if (sh >= trial) begin
			nxt.rem  = 34'(sh - trial);
			nxt.root = {cur.root[30:0], 1'b1};
		end else begin
			nxt.rem  = sh[33:0];
			nxt.root = {cur.root[30:0], 1'b0};
		end
		return nxt;
	endfunction

	// one bit of a restoring division
	function automatic gvr_div_t div_step(logic [32:0] rem, logic nb, logic [31:0] dvs);
		logic [33:0] sh;
		gvr_div_t    nxt;
		sh = {rem, nb};
		if (sh >= {2'b00, dvs}) begin
			nxt.rem  = 33'(sh - {2'b00, dvs});
			nxt.qbit = 1'b1;
		end else begin
			nxt.rem  = sh[32:0];
			nxt.qbit = 1'b0;
		end
		return nxt;
	endfunction

endpackage

// ===== sv/gvr_in_if.sv =====
// ----------------------------------------------------------------------------
// gvr_in_if: input pair channel
// Valid/ready channel carrying the components a and b.
// ----------------------------------------------------------------------------
interface gvr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] a_value;
	logic signed [31:0] b_value;

	modport source (output valid, a_value, b_value, input ready);
	modport sink   (input valid, a_value, b_value, output ready);
endinterface

// ===== sv/gvr_out_if.sv =====
// ----------------------------------------------------------------------------
// gvr_out_if: rotation result channel
// Valid/ready channel carrying r, c, s and the reconstruction value.
// ----------------------------------------------------------------------------
interface gvr_out_if;
	logic               valid;
	logic               ready;
	logic signed [32:0] radius;
	logic signed [31:0] cosine;
	logic signed [31:0] sine;
	logic signed [31:0] recon_value;
	logic               recon_saturated;

	modport source (output valid, radius, cosine, sine, recon_value, recon_saturated,
		input ready);
	modport sink   (input valid, radius, cosine, sine, recon_value, recon_saturated,
		output ready);
endinterface

// ===== sv/gvr_front.sv =====
// ----------------------------------------------------------------------------
// gvr_front: accept and classify
// Registers the pair, forms magnitudes and case flags, squares both parts
// and pushes the work word with its square sum into the queue.
// ----------------------------------------------------------------------------
module gvr_front (
	input  logic              clk,
	input  logic              arst_n,
	gvr_in_if.sink            pair,
	output gvr_pkg::gvr_work_t push_data,
	output logic              push_valid,
	input  logic              push_ready
);
	import gvr_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic               rdy1, rdy2, rdy3;
	logic signed [31:0] a_s1, b_s1;
	gvr_cls_t           cls_s2, cls_s3;
	logic        [63:0] asq_s3, bsq_s3;
	gvr_cls_t           cls_c;

	// bubbles collapse: a stage takes a word when empty or when it drains
	assign rdy3       = !v_s3 || push_ready;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign pair.ready = rdy1;

	always_comb begin
		cls_c.aneg = a_s1[31];
		cls_c.bneg = b_s1[31];
		cls_c.amag = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
		cls_c.bmag = b_s1[31] ? 32'(-b_s1) : 32'(b_s1);
		cls_c.abig = cls_c.amag > cls_c.bmag;
		cls_c.zero = (cls_c.amag == 32'd0) && (cls_c.bmag == 32'd0);
		cls_c.rneg = cls_c.zero ? 1'b0 : (cls_c.abig ? cls_c.aneg : cls_c.bneg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pair.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			a_s1 <= pair.a_value;
			b_s1 <= pair.b_value;
		end
		if (rdy2) cls_s2 <= cls_c;
		if (rdy3) begin
			cls_s3 <= cls_s2;
			asq_s3 <= cls_s2.amag * cls_s2.amag;
			bsq_s3 <= cls_s2.bmag * cls_s2.bmag;
		end
	end

	assign push_valid    = v_s3;
	assign push_data.cls = cls_s3;
	assign push_data.sum = asq_s3 + bsq_s3;

endmodule

// ===== sv/gvr_fifo.sv =====
// ----------------------------------------------------------------------------
// gvr_fifo: work queue
// Short queue between the classify front and the arithmetic back.
// ----------------------------------------------------------------------------
module gvr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  gvr_pkg::gvr_work_t push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output gvr_pkg::gvr_work_t pop_data,
	input  logic               pop_ready
);
	import gvr_pkg::*;

	gvr_work_t        mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic             push, pop;

	assign push_ready = count_q != (QPtrW+1)'(QueueDepth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPtrW+1)'(QueueDepth))
		else $error("queue count beyond depth");
`endif

endmodule

// ===== sv/gvr_back.sv =====
// ----------------------------------------------------------------------------
// gvr_back: rotation arithmetic
// Bit-per-stage square root, division for c and s, reciprocal of c and
// the output register. The whole pipeline advances together.
// ----------------------------------------------------------------------------
module gvr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  gvr_pkg::gvr_work_t pop_data,
	output logic               pop_ready,
	gvr_out_if.source          rot
);
	import gvr_pkg::*;

	logic en;

	logic [SqrtSteps:0]  sq_v_s;
	logic [DivSteps:0]   dv_v_s;
	logic [RecipSteps:0] rc_v_s;
	logic                out_v_q;

	gvr_cls_t    sq_cls_s [0:SqrtSteps];
	logic [63:0] sq_sum_s [0:SqrtSteps];
	gvr_sq_t     sq_st_s  [0:SqrtSteps];

	gvr_cls_t    dv_cls_s  [0:DivSteps];
	logic [31:0] dv_rmag_s [0:DivSteps];
	logic [31:0] dv_dvs_s  [0:DivSteps];
	logic [32:0] dv_crem_s [0:DivSteps];
	logic [32:0] dv_srem_s [0:DivSteps];
	logic [30:0] dv_cdvd_s [0:DivSteps];
	logic [30:0] dv_sdvd_s [0:DivSteps];
	logic [30:0] dv_cq_s   [0:DivSteps];
	logic [30:0] dv_sq_s   [0:DivSteps];
	gvr_div_t    dv_cnx    [1:DivSteps];
	gvr_div_t    dv_snx    [1:DivSteps];

	gvr_cls_t    rc_cls_s  [0:RecipSteps];
	logic [31:0] rc_rmag_s [0:RecipSteps];
	logic [30:0] rc_cmag_s [0:RecipSteps];
	logic [30:0] rc_smag_s [0:RecipSteps];
	logic [32:0] rc_rem_s  [0:RecipSteps];
	logic [31:0] rc_q_s    [0:RecipSteps];
	gvr_div_t    rc_nx     [1:RecipSteps];

	logic signed [32:0] out_rad_q;
	logic signed [31:0] out_cos_q, out_sin_q, out_z_q;
	logic               out_sat_q;

	gvr_cls_t    f_cls;
	logic [30:0] f_cmag, f_smag;
	logic [31:0] f_q;
	logic        f_cneg, f_sneg;
	logic [16:0] f_zm;
	logic [32:0] f_rad;
	logic [31:0] f_cos, f_sin, f_z;
	logic        f_sat;

	// stall the whole back while the result waits
	assign en        = !out_v_q || rot.ready;
	assign pop_ready = en;

	always_comb begin
		for (int k = 1; k <= DivSteps; k++) begin
			dv_cnx[k] = div_step(dv_crem_s[k-1], dv_cdvd_s[k-1][30], dv_dvs_s[k-1]);
			dv_snx[k] = div_step(dv_srem_s[k-1], dv_sdvd_s[k-1][30], dv_dvs_s[k-1]);
		end
		for (int k = 1; k <= RecipSteps; k++) begin
			rc_nx[k] = div_step(rc_rem_s[k-1], 1'b0, {1'b0, rc_cmag_s[k-1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s  <= '0;
			dv_v_s  <= '0;
			rc_v_s  <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			sq_v_s  <= {sq_v_s[SqrtSteps-1:0], pop_valid};
			dv_v_s  <= {dv_v_s[DivSteps-1:0], sq_v_s[SqrtSteps]};
			rc_v_s  <= {rc_v_s[RecipSteps-1:0], dv_v_s[DivSteps]};
			out_v_q <= rc_v_s[RecipSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_cls_s[0] <= pop_data.cls;
			sq_sum_s[0] <= pop_data.sum;
			sq_st_s[0]  <= '0;
			for (int k = 1; k <= SqrtSteps; k++) begin
				sq_cls_s[k] <= sq_cls_s[k-1];
				sq_sum_s[k] <= {sq_sum_s[k-1][61:0], 2'b00};
				sq_st_s[k]  <= sqrt_step(sq_st_s[k-1], sq_sum_s[k-1][63:62]);
			end

			dv_cls_s[0]  <= sq_cls_s[SqrtSteps];
			dv_rmag_s[0] <= sq_st_s[SqrtSteps].root;
			// both parts zero: divide one by one so that c comes out as 1.0
			dv_dvs_s[0]  <= sq_cls_s[SqrtSteps].zero ? 32'd1 : sq_st_s[SqrtSteps].root;
			dv_crem_s[0] <= {2'b00, sq_cls_s[SqrtSteps].amag[31:1]};
			dv_srem_s[0] <= {2'b00, sq_cls_s[SqrtSteps].bmag[31:1]};
			dv_cdvd_s[0] <= {sq_cls_s[SqrtSteps].amag[0] | sq_cls_s[SqrtSteps].zero, 30'd0};
			dv_sdvd_s[0] <= {sq_cls_s[SqrtSteps].bmag[0], 30'd0};
			dv_cq_s[0]   <= '0;
			dv_sq_s[0]   <= '0;
			for (int k = 1; k <= DivSteps; k++) begin
				dv_cls_s[k]  <= dv_cls_s[k-1];
				dv_rmag_s[k] <= dv_rmag_s[k-1];
				dv_dvs_s[k]  <= dv_dvs_s[k-1];
				dv_crem_s[k] <= dv_cnx[k].rem;
				dv_srem_s[k] <= dv_snx[k].rem;
				dv_cdvd_s[k] <= {dv_cdvd_s[k-1][29:0], 1'b0};
				dv_sdvd_s[k] <= {dv_sdvd_s[k-1][29:0], 1'b0};
				dv_cq_s[k]   <= {dv_cq_s[k-1][29:0], dv_cnx[k].qbit};
				dv_sq_s[k]   <= {dv_sq_s[k-1][29:0], dv_snx[k].qbit};
			end

			rc_cls_s[0]  <= dv_cls_s[DivSteps];
			rc_rmag_s[0] <= dv_rmag_s[DivSteps];
			rc_cmag_s[0] <= dv_cq_s[DivSteps];
			rc_smag_s[0] <= dv_sq_s[DivSteps];
			rc_rem_s[0]  <= {2'b00, RecipSmall};
			rc_q_s[0]    <= '0;
			for (int k = 1; k <= RecipSteps; k++) begin
				rc_cls_s[k]  <= rc_cls_s[k-1];
				rc_rmag_s[k] <= rc_rmag_s[k-1];
				rc_cmag_s[k] <= rc_cmag_s[k-1];
				rc_smag_s[k] <= rc_smag_s[k-1];
				rc_rem_s[k]  <= rc_nx[k].rem;
				rc_q_s[k]    <= {rc_q_s[k-1][30:0], rc_nx[k].qbit};
			end

			out_rad_q <= f_rad;
			out_cos_q <= f_cos;
			out_sin_q <= f_sin;
			out_z_q   <= f_z;
			out_sat_q <= f_sat;
		end
	end

	// apply signs and pick the reconstruction value
	always_comb begin
		f_cls  = rc_cls_s[RecipSteps];
		f_cmag = rc_cmag_s[RecipSteps];
		f_smag = rc_smag_s[RecipSteps];
		f_q    = rc_q_s[RecipSteps];
		f_cneg = (f_cls.aneg != f_cls.rneg) && (f_cmag != '0);
		f_sneg = (f_cls.bneg != f_cls.rneg) && (f_smag != '0);
		f_zm   = f_smag[30:14];
		f_rad  = f_cls.rneg ? -{1'b0, rc_rmag_s[RecipSteps]} : {1'b0, rc_rmag_s[RecipSteps]};
		f_cos  = f_cneg ? -{1'b0, f_cmag} : {1'b0, f_cmag};
		f_sin  = f_sneg ? -{1'b0, f_smag} : {1'b0, f_smag};
		f_sat  = 1'b0;
		priority if (f_cls.abig) begin
			f_z = f_sneg ? -{15'd0, f_zm} : {15'd0, f_zm};
		end else if (f_cmag == '0) begin
			f_z = ZOneQ16;
		end else if (f_cmag <= RecipSmall) begin
			// quotient beyond 32 bits: clamp at once
			f_sat = 1'b1;
			f_z   = f_cneg ? ZNegMin : ZPosMax;
		end else if (!f_cneg) begin
			f_sat = f_q > ZPosMax;
			f_z   = f_sat ? ZPosMax : f_q;
		end else begin
			f_sat = f_q > ZNegMin;
			f_z   = f_sat ? ZNegMin : -f_q;
		end
	end

	assign rot.valid           = out_v_q;
	assign rot.radius          = out_rad_q;
	assign rot.cosine          = out_cos_q;
	assign rot.sine            = out_sin_q;
	assign rot.recon_value     = out_z_q;
	assign rot.recon_saturated = out_sat_q;

`ifndef SYNTH
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DivSteps] |-> (dv_cq_s[DivSteps] <= OneQ30) && (dv_sq_s[DivSteps] <= OneQ30))
		else $error("c or s magnitude above one");
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_sat_q) |-> (out_z_q == ZPosMax) || (out_z_q == ZNegMin))
		else $error("saturation flag without clamped value");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rc_v_s) && $stable(sq_v_s))
		else $error("pipeline moved while stalled");
`endif

endmodule

// ===== sv/givens_rotation_construct.sv =====
// Throughput: one pair per cycle while the output is not stalled; the square root,
//   c/s division and 1/c reciprocal are each one bit per pipeline stage.
// Reset: arst_n clears all valid state asynchronously; payload is not reset.
// Output stalls freeze the back pipeline; the front keeps filling a 4-word queue.
// ----------------------------------------------------------------------------
// givens_rotation_construct: plane rotation construction
// Top level joining the classify front, work queue and arithmetic back.
// ----------------------------------------------------------------------------
module givens_rotation_construct (
	input  logic      clk,
	input  logic      arst_n,
	gvr_in_if.sink    pair,
	gvr_out_if.source rot
);
	import gvr_pkg::*;

	gvr_work_t push_data, pop_data;
	logic      push_valid, push_ready, pop_valid, pop_ready;

	gvr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	gvr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	gvr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.rot       (rot)
	);

endmodule
